### rtl/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Shared constants, register indexes, level tables and types for the
// flashlight ramp controller.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int NUM_LEVELS = 64;
  localparam int LEVEL_W    = 6;
  localparam logic [LEVEL_W-1:0] TOP_LEVEL =
    LEVEL_W'((NUM_LEVELS - 1) > 63 ? 63 : (NUM_LEVELS - 1));
  localparam logic [LEVEL_W-1:0] STEP_DOWN = LEVEL_W'(NUM_LEVELS / 8);

  localparam logic [3:0] DEBOUNCE_MASK = 4'b1111;
  localparam logic [7:0] WINDOW_RESET  = 8'd169;
  localparam logic [7:0] COUNT_MAX     = 8'd255;

  // configuration register indexes
  localparam logic [2:0] REG_LONG_PRESS_UNIT    = 3'd0;
  localparam logic [2:0] REG_RAMP_TIMEOUT       = 3'd1;
  localparam logic [2:0] REG_LOW_THRESHOLD      = 3'd2;
  localparam logic [2:0] REG_CRITICAL_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_STEP_DOWN_DELAY    = 3'd4;
  localparam logic [2:0] REG_GREEN_THRESHOLD    = 3'd5;
  localparam logic [2:0] REG_YELLOW_THRESHOLD   = 3'd6;

  // indicator codes
  localparam logic [1:0] IND_OFF    = 2'd0;
  localparam logic [1:0] IND_GREEN  = 2'd1;
  localparam logic [1:0] IND_YELLOW = 2'd2;
  localparam logic [1:0] IND_RED    = 2'd3;

  localparam logic [7:0] DUTY_TABLE [64] = '{
    8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3,
    8'd3, 8'd4, 8'd4, 8'd5, 8'd5, 8'd6, 8'd6, 8'd7,
    8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
    8'd16, 8'd17, 8'd19, 8'd21, 8'd23, 8'd25, 8'd27, 8'd30,
    8'd33, 8'd36, 8'd39, 8'd43, 8'd47, 8'd52, 8'd56, 8'd62,
    8'd68, 8'd74, 8'd81, 8'd89, 8'd97, 8'd106, 8'd116, 8'd127,
    8'd139, 8'd153, 8'd167, 8'd183, 8'd200, 8'd219, 8'd239, 8'd255
  };

  localparam logic [7:0] TOP_TABLE [64] = '{
    8'd255, 8'd255, 8'd228, 8'd203, 8'd177, 8'd147, 8'd116, 8'd81,
    8'd52, 8'd248, 8'd225, 8'd199, 8'd171, 8'd140, 8'd237, 8'd212,
    8'd185, 8'd241, 8'd217, 8'd253, 8'd229, 8'd253, 8'd230, 8'd247,
    8'd222, 8'd234, 8'd242, 8'd246, 8'd247, 8'd247, 8'd244, 8'd240,
    8'd251, 8'd244, 8'd249, 8'd252, 8'd252, 8'd251, 8'd247, 8'd251,
    8'd253, 8'd252, 8'd249, 8'd251, 8'd251, 8'd254, 8'd250, 8'd253,
    8'd254, 8'd252, 8'd253, 8'd254, 8'd253, 8'd252, 8'd252, 8'd253,
    8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255
  };

  // switch status handed from the ramp logic to the battery monitor
  typedef struct packed {
    logic pressed;
    logic idle;
  } frc_sw_t;

  // battery thresholds and step-down delay
  typedef struct packed {
    logic [7:0] low_thr;
    logic [7:0] crit_thr;
    logic [7:0] delay;
    logic [7:0] green_thr;
    logic [7:0] yellow_thr;
  } frc_batt_cfg_t;

endpackage

### rtl/frc_batt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_batt
// Battery monitor: four-sample window, average, indicator and the low
// reading counter that requests a step-down.
// ----------------------------------------------------------------------------
module frc_batt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  frc_pkg::frc_sw_t       sw,
  input  logic                   sample_ready,
  input  logic [7:0]             battery_sample,
  input  logic                   level_one,
  input  frc_pkg::frc_batt_cfg_t cfg,
  output logic                   step_down,
  output logic [1:0]             indicator
);
  import frc_pkg::*;

  logic [7:0] win_r [4];
  logic [7:0] win_nxt [4];
  logic [7:0] low_count_r, low_count_nxt;
  logic [1:0] ind_r, ind_nxt;
  logic [9:0] sum;
  logic [7:0] avg, thr, low_upd;
  logic       take;

  assign take = sw.idle && sample_ready;
  assign sum  = 10'(win_r[1]) + 10'(win_r[2]) + 10'(win_r[3]) + 10'(battery_sample);
  assign avg  = sum[9:2];
  assign thr  = level_one ? cfg.crit_thr : cfg.low_thr;

  always_comb begin
    win_nxt[0] = win_r[0];
    win_nxt[1] = win_r[1];
    win_nxt[2] = win_r[2];
    win_nxt[3] = win_r[3];
    ind_nxt    = ind_r;
    low_upd    = low_count_r;
    step_down  = 1'b0;
    if (take) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = win_r[3];
      win_nxt[3] = battery_sample;
      low_upd    = (avg < thr) ? low_count_r + 8'd1 : 8'd0;
      priority if (avg > cfg.green_thr) begin
        ind_nxt = IND_GREEN;
      end else if (avg > cfg.yellow_thr) begin
        ind_nxt = IND_YELLOW;
      end else begin
        ind_nxt = IND_RED;
      end
    end
    low_count_nxt = low_upd;
    if (sw.pressed) begin
      low_count_nxt = 8'd0;
    end else if (sw.idle && low_upd >= cfg.delay) begin
      step_down     = 1'b1;
      low_count_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) win_r[i] <= WINDOW_RESET;
      low_count_r <= 8'd0;
      ind_r       <= IND_OFF;
    end else if (adv) begin
      for (int i = 0; i < 4; i++) win_r[i] <= win_nxt[i];
      low_count_r <= low_count_nxt;
      ind_r       <= ind_nxt;
    end
  end

  assign indicator = ind_nxt;

endmodule

### rtl/frc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ctrl
// Switch debounce, hold timing, ramping, toggling, direction and the
// on-time timeout; applies the battery step-down to the level.
// ----------------------------------------------------------------------------
module frc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         switch_pressed,
  input  logic [4:0]                   unit,
  input  logic [7:0]                   timeout,
  input  logic                         step_down,
  output frc_pkg::frc_sw_t             sw,
  output logic [frc_pkg::LEVEL_W-1:0]  level,
  output logic [frc_pkg::LEVEL_W-1:0]  level_nxt,
  output logic                         dir_nxt
);
  import frc_pkg::*;

  logic [3:0]         hist_r, hist_nxt;
  logic [LEVEL_W-1:0] level_r, saved_r, saved_nxt;
  logic               dir_r;
  logic [7:0]         hold_r, hold_nxt, on_r, on_nxt, on0, hold1;
  logic [8:0]         unit8;
  logic [7:0]         unit7;
  logic               pressed, rev;
  logic [LEVEL_W-1:0] ramp_lvl, lvl_mid;

  assign hist_nxt = {hist_r[2:0], switch_pressed} & DEBOUNCE_MASK;
  assign pressed  = hist_nxt != 4'd0;
  assign unit8    = {1'b0, unit, 3'b000};
  assign unit7    = {unit, 3'b000} - {3'b000, unit};
  assign on0      = (level_r == '0) ? 8'd0 : on_r;
  assign hold1    = (hold_r != COUNT_MAX) ? hold_r + 8'd1 : hold_r;

  assign sw.pressed = pressed;
  assign sw.idle    = !pressed && hold_r == 8'd0;

  always_comb begin
    if (dir_r) begin
      ramp_lvl = (level_r >= TOP_LEVEL) ? TOP_LEVEL : level_r + LEVEL_W'(1);
    end else begin
      ramp_lvl = (level_r <= LEVEL_W'(1)) ? LEVEL_W'(1) : level_r - LEVEL_W'(1);
    end
  end

  always_comb begin
    lvl_mid   = level_r;
    saved_nxt = saved_r;
    hold_nxt  = hold_r;
    on_nxt    = on0;
    rev       = 1'b0;
    if (pressed) begin
      hold_nxt = hold1;
      if ({1'b0, hold1} + 9'd1 == unit8) lvl_mid = ramp_lvl;
      if ({1'b0, hold1} == unit8) hold_nxt = unit7;
    end else begin
      if (level_r != '0 && on0 != COUNT_MAX) on_nxt = on0 + 8'd1;
      if (hold_r != 8'd0 && hold_r < unit7) begin
        // short press toggles off and the saved level
        if (level_r == '0) begin
          lvl_mid = saved_r;
        end else begin
          saved_nxt = level_r;
          lvl_mid   = '0;
        end
      end else if (hold_r != 8'd0) begin
        rev = 1'b1;
      end else begin
        rev = (on_nxt == timeout);
      end
      hold_nxt = 8'd0;
    end
    if (rev) begin
      priority if (level_r <= LEVEL_W'(1)) begin
        dir_nxt = 1'b1;
      end else if (level_r >= TOP_LEVEL) begin
        dir_nxt = 1'b0;
      end else begin
        dir_nxt = !dir_r;
      end
    end else begin
      dir_nxt = dir_r;
    end
    level_nxt = lvl_mid;
    if (step_down) begin
      level_nxt = (level_r <= STEP_DOWN) ? LEVEL_W'(1) : level_r - STEP_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= 4'd0;
      level_r <= '0;
      dir_r   <= 1'b1;
      hold_r  <= 8'd0;
      on_r    <= 8'd0;
      saved_r <= '0;
    end else if (adv) begin
      hist_r  <= hist_nxt;
      level_r <= level_nxt;
      dir_r   <= dir_nxt;
      hold_r  <= hold_nxt;
      on_r    <= on_nxt;
      saved_r <= saved_nxt;
    end
  end

  assign level = level_r;

endmodule

### rtl/flashlight_ramp_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flashlight_ramp_controller_unit
// Flashlight ramping controller, one input word per 16 ms tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per tick; in_tdata[0] raw switch, in_tdata[8:1]
//           battery reading, in_tuser flags a fresh battery reading.
//   out_* : one word per input word with level, pwm duty, pwm top,
//           indicator and ramp direction.
//   cfg_* : register writes, only while no word is in flight.
// Path: an accepted word is held in the input register, and its result is
//   captured in the output register and presented on out_*.
// Throughput: one word per cycle while out_tready stays high; the tick
//   logic is combinational between the input and the output register.
// Reset (rst_n low, synchronous): config registers go to their defaults,
//   the level is off, ramp direction up, battery window filled with 169.
// Stall: while out_tready is low the result is held; one more input word
//   is taken into the input register, after which in_tready drops.
// ----------------------------------------------------------------------------
module flashlight_ramp_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // switch_pressed, battery_sample, zero pad
  input  logic        in_tuser,   // sample_ready
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // level_index, pwm_duty, pwm_top, indicator,
                                  // ramping_up, zero pad
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import frc_pkg::*;

  logic [4:0]         unit_r;
  logic [7:0]         timeout_r;
  frc_batt_cfg_t      bcfg_r;

  logic               in_valid_r, out_valid_r, adv;
  logic               sw_in_r, smp_rdy_r;
  logic [7:0]         smp_r;
  frc_sw_t            sw;
  logic               step_down;
  logic [1:0]         ind;
  logic [LEVEL_W-1:0] level, level_nxt;
  logic               dir_nxt;
  logic [LEVEL_W-1:0] out_level_r;
  logic [7:0]         out_duty_r, out_top_r;
  logic [1:0]         out_ind_r;
  logic               out_dir_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r            <= 5'd4;
      timeout_r         <= 8'd120;
      bcfg_r.low_thr    <= 8'd123;
      bcfg_r.crit_thr   <= 8'd113;
      bcfg_r.delay      <= 8'd188;
      bcfg_r.green_thr  <= 8'd154;
      bcfg_r.yellow_thr <= 8'd139;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LONG_PRESS_UNIT:    unit_r            <= cfg_wdata[4:0];
        REG_RAMP_TIMEOUT:       timeout_r         <= cfg_wdata;
        REG_LOW_THRESHOLD:      bcfg_r.low_thr    <= cfg_wdata;
        REG_CRITICAL_THRESHOLD: bcfg_r.crit_thr   <= cfg_wdata;
        REG_STEP_DOWN_DELAY:    bcfg_r.delay      <= cfg_wdata;
        REG_GREEN_THRESHOLD:    bcfg_r.green_thr  <= cfg_wdata;
        REG_YELLOW_THRESHOLD:   bcfg_r.yellow_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register feeds the tick logic, output register holds the result
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sw_in_r   <= in_tdata[0];
      smp_r     <= in_tdata[8:1];
      smp_rdy_r <= in_tuser;
    end
    if (adv) begin
      out_level_r <= level_nxt;
      out_duty_r  <= DUTY_TABLE[level_nxt];
      out_top_r   <= TOP_TABLE[level_nxt];
      out_ind_r   <= ind;
      out_dir_r   <= dir_nxt;
    end
  end

  frc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .switch_pressed (sw_in_r),
    .unit           (unit_r),
    .timeout        (timeout_r),
    .step_down      (step_down),
    .sw             (sw),
    .level          (level),
    .level_nxt      (level_nxt),
    .dir_nxt        (dir_nxt)
  );

  frc_batt u_batt (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .sw             (sw),
    .sample_ready   (smp_rdy_r),
    .battery_sample (smp_r),
    .level_one      (level == LEVEL_W'(1)),
    .cfg            (bcfg_r),
    .step_down      (step_down),
    .indicator      (ind)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_dir_r, out_ind_r, out_top_r, out_duty_r, out_level_r};

  // a full input register behind a stalled result must hold off the sender
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is blocked");

  // the tick logic only advances when a word is processed
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(level))
    else $error("level changed without a processed word");

  // a step-down never happens during a press
  a_no_step_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    sw.pressed |-> !step_down)
    else $error("step-down while switch pressed");

  // an output word with the level off carries zero duty
  a_off_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_level_r == '0 |-> out_duty_r == 8'd0)
    else $error("nonzero duty with level off");

endmodule

### tb/frc_ramp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ramp_checker
// Watches the tick, result and register ports of the flashlight ramp
// controller. It keeps its own copy of the switch, level and battery state,
// predicts the lamp word for every accepted tick and compares each result
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module frc_ramp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          peak_level
);
  import frc_pkg::*;

  typedef struct packed {
    logic       ramping_up;
    logic [1:0] indicator;
    logic [7:0] pwm_top;
    logic [7:0] pwm_duty;
    logic [5:0] level_index;
  } lamp_t;

  lamp_t expected_lamp [$];

  // register copies
  logic [4:0] c_unit;
  logic [7:0] c_timeout, c_low, c_crit, c_delay, c_green, c_yellow;

  // controller state
  logic [3:0]         sw_hist;
  logic [LEVEL_W-1:0] lvl, saved_lvl;
  logic               dir_up;
  logic [7:0]         hold_cnt, on_cnt, low_run;
  logic [7:0]         vwin [4];
  logic [1:0]         ind_state;

  function automatic void reset_model();
    c_unit    = 5'd4;
    c_timeout = 8'd120;
    c_low     = 8'd123;
    c_crit    = 8'd113;
    c_delay   = 8'd188;
    c_green   = 8'd154;
    c_yellow  = 8'd139;
    sw_hist   = 4'b0;
    lvl       = '0;
    saved_lvl = '0;
    dir_up    = 1'b1;
    hold_cnt  = 8'd0;
    on_cnt    = 8'd0;
    low_run   = 8'd0;
    ind_state = IND_OFF;
    for (int i = 0; i < 4; i++) vwin[i] = WINDOW_RESET;
  endfunction

  function automatic void clamp_level(input int v);
    if (v <= 0) v = 1;
    if (v > int'(TOP_LEVEL)) v = int'(TOP_LEVEL);
    lvl = LEVEL_W'(v);
  endfunction

  function automatic void flip_direction();
    dir_up = ~dir_up;
    if (lvl <= 1) dir_up = 1'b1;
    if (lvl >= TOP_LEVEL) dir_up = 1'b0;
  endfunction

  function automatic lamp_t advance_tick(input logic sw, input logic fresh,
                                         input logic [7:0] batt);
    int    unit8, unit7, sum;
    logic  pressed;
    logic [7:0] avg, thr;
    lamp_t r;
    unit8   = int'(c_unit) * 8;
    unit7   = int'(c_unit) * 7;
    sw_hist = {sw_hist[2:0], sw} & DEBOUNCE_MASK;
    pressed = (sw_hist != 4'b0);
    if (lvl == 0) on_cnt = 8'd0;
    if (pressed) begin
      if (hold_cnt != COUNT_MAX) hold_cnt = hold_cnt + 8'd1;
      if (int'(hold_cnt) == unit8 - 1) clamp_level(int'(lvl) + (dir_up ? 1 : -1));
      // wrap back so the next step comes one unit later
      if (int'(hold_cnt) == unit8) hold_cnt = 8'(unit7);
      low_run = 8'd0;
    end else begin
      if (lvl != 0 && on_cnt != COUNT_MAX) on_cnt = on_cnt + 8'd1;
      if (hold_cnt > 0 && int'(hold_cnt) < unit7) begin
        if (lvl == 0) begin
          lvl = saved_lvl;
        end else begin
          saved_lvl = lvl;
          lvl = '0;
        end
      end else if (hold_cnt > 0) begin
        flip_direction();
      end else begin
        if (on_cnt == c_timeout) flip_direction();
        if (fresh) begin
          for (int i = 0; i < 3; i++) vwin[i] = vwin[i+1];
          vwin[3] = batt;
          sum = 0;
          for (int i = 0; i < 4; i++) sum = sum + int'(vwin[i]);
          avg = 8'(sum / 4);
          thr = (lvl == 1) ? c_crit : c_low;
          if (avg < thr) low_run = low_run + 8'd1;
          else low_run = 8'd0;
          if (avg > c_green) ind_state = IND_GREEN;
          else if (avg > c_yellow) ind_state = IND_YELLOW;
          else ind_state = IND_RED;
        end
        if (low_run >= c_delay) begin
          clamp_level(int'(lvl) - int'(STEP_DOWN));
          low_run = 8'd0;
        end
      end
      hold_cnt = 8'd0;
    end
    r.level_index = lvl;
    r.pwm_duty    = DUTY_TABLE[lvl];
    r.pwm_top     = TOP_TABLE[lvl];
    r.indicator   = ind_state;
    r.ramping_up  = dir_up;
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    lamp_t got, want;
    if (!rst_n) begin
      reset_model();
      expected_lamp.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_LONG_PRESS_UNIT:    c_unit    = cfg_wdata[4:0];
          REG_RAMP_TIMEOUT:       c_timeout = cfg_wdata;
          REG_LOW_THRESHOLD:      c_low     = cfg_wdata;
          REG_CRITICAL_THRESHOLD: c_crit    = cfg_wdata;
          REG_STEP_DOWN_DELAY:    c_delay   = cfg_wdata;
          REG_GREEN_THRESHOLD:    c_green   = cfg_wdata;
          REG_YELLOW_THRESHOLD:   c_yellow  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_lamp.push_back(advance_tick(in_tdata[0], in_tuser, in_tdata[8:1]));
      if (out_tvalid && out_tready) begin
        got = lamp_t'(out_tdata[24:0]);
        results_seen++;
        if (int'(got.level_index) > peak_level) peak_level = int'(got.level_index);
        if (expected_lamp.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_lamp.pop_front();
          check_field("level_index", want.level_index, got.level_index);
          check_field("pwm_duty", want.pwm_duty, got.pwm_duty);
          check_field("pwm_top", want.pwm_top, got.pwm_top);
          check_field("indicator", want.indicator, got.indicator);
          check_field("ramping_up", want.ramping_up, got.ramping_up);
        end
      end
    end
    pending = expected_lamp.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick words into the flashlight ramp controller: a short directed
// run through the switch and battery corner cases, then random press, hold,
// idle and noise episodes under several register settings, with random
// gaps and stalls on both channels. The checker judges every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import frc_pkg::*;

  localparam int LIMIT     = 800000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_LEN = 188;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  int fail_count, pending, results_seen, peak_level;
  int ticks_sent = 0;
  int cycle_cnt = 0;
  int settings_run = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  // copies of what was last written, used to aim the battery readings and hold lengths
  logic [4:0] s_unit = 5'd4;
  logic [7:0] s_low = 8'd123, s_crit = 8'd113, s_green = 8'd154;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  flashlight_ramp_controller_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  frc_ramp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .peak_level   (peak_level)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] battery_level(input int band);
    int v, d;
    d = $urandom_range(1, 40);
    case (band)
      1: v = int'(s_low) + (d % 17) - 8;
      2: v = int'(s_green) + d;
      3: v = int'(s_crit) - d;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // receiver: random stalls, and one long hold-off on request
  initial begin : receiver
    int n;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = stall_len();
        if (n == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so the next word can follow back to back
  task automatic push_tick(input logic sw, input logic fresh, input logic [7:0] batt);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, batt, sw};
    in_tuser  <= fresh;
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [4:0] unit, input logic [7:0] tmo,
                               input logic [7:0] low, input logic [7:0] crit,
                               input logic [7:0] dly, input logic [7:0] green,
                               input logic [7:0] yellow);
    drain();
    put_reg(REG_LONG_PRESS_UNIT, {3'b0, unit});
    put_reg(REG_RAMP_TIMEOUT, tmo);
    put_reg(REG_LOW_THRESHOLD, low);
    put_reg(REG_CRITICAL_THRESHOLD, crit);
    put_reg(REG_STEP_DOWN_DELAY, dly);
    put_reg(REG_GREEN_THRESHOLD, green);
    put_reg(REG_YELLOW_THRESHOLD, yellow);
    cfg_wen <= 1'b0;
    s_unit  = unit;
    s_low   = low;
    s_crit  = crit;
    s_green = green;
    settings_run++;
  endtask

  // switch held for k ticks, then released long enough for debounce to clear
  task automatic hold_switch(input int k, input int band);
    int tail;
    tail = $urandom_range(4, 9);
    for (int i = 0; i < k; i++) push_tick(1'b1, 1'($urandom_range(0, 1)), battery_level(band));
    for (int i = 0; i < tail; i++)
      push_tick(1'b0, 1'($urandom_range(0, 1)), battery_level(band));
  endtask

  task automatic run_episode();
    int kind, band, k, lim;
    band   = $urandom_range(0, 3);
    steady = ($urandom_range(0, 4) == 0);
    kind   = $urandom_range(0, 99);
    if (kind < 33) begin
      lim = int'(s_unit) * 7 - 4;
      if (lim > 12) lim = 12;
      if (lim < 1) lim = 1;
      hold_switch($urandom_range(1, lim), band);
    end else if (kind < 60) begin
      k = int'(s_unit) * 8 + $urandom_range(1, 70);
      hold_switch(k, band);
    end else if (kind < 90) begin
      k = $urandom_range(4, 30);
      for (int i = 0; i < k; i++)
        push_tick(1'b0, ($urandom_range(0, 3) != 0), battery_level(band));
    end else begin
      k = $urandom_range(2, 10);
      for (int i = 0; i < k; i++)
        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 16'h0;
    in_tuser  = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = REG_LONG_PRESS_UNIT;
    cfg_wdata = 8'h0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: battery extremes, samples ignored while pressed,
    // and a first short press from off that has no saved level to restore
    push_tick(1'b0, 1'b1, 8'hFF);
    push_tick(1'b0, 1'b1, 8'h00);
    push_tick(1'b1, 1'b1, 8'hAA);
    push_tick(1'b0, 1'b1, 8'h55);
    push_tick(1'b0, 1'b0, 8'h00);
    push_tick(1'b0, 1'b1, 8'h0F);
    push_tick(1'b0, 1'b0, 8'h00);

    // zero hold unit, instant step-down: low reading while off lands on
    // level one, critical threshold takes over there, releases reverse
    load_settings(5'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd255, 8'd0);
    push_tick(1'b0, 1'b1, 8'h00);
    push_tick(1'b0, 1'b1, 8'hF0);
    hold_switch(1, 0);
    hold_switch(3, 0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_settings(5'd1, 8'($urandom_range(5, 40)), 8'd140, 8'd120, 8'd2,
                         8'd170, 8'd140);
        1: load_settings(5'd2, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
        2: load_settings(5'd31, 8'd255, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255);
        3: load_settings(5'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
        4: load_settings(5'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
        default: load_settings(5'd1, 8'($urandom_range(0, 60)),
                               8'($urandom_range(100, 200)), 8'($urandom_range(80, 160)),
                               8'($urandom_range(1, 6)), 8'($urandom_range(150, 220)),
                               8'($urandom_range(100, 150)));
      endcase
      // back up the result side while ticks keep coming
      if (p == 0) hold_off_req = 1'b1;
      while (ticks_sent < 22 + (p + 1) * PHASE_LEN) run_episode();
    end

    steady = 1'b0;
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d ticks under %0d register settings, %0d results checked",
             ticks_sent, settings_run + 1, results_seen);
    $display("highest level index seen %0d, %0d cycles", peak_level, cycle_cnt);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
